[rtl/core/fplog_pkg.sv]
// types and helpers for the pseudo log2 / exp2 single-float converter
// no dependencies
package fplog_pkg;

   localparam logic [7:0] LOW_EXP_RESET = 8'd127;
   localparam logic [7:0] EXP_ALL_ONES  = 8'hFF;
   localparam logic [7:0] EXP_MAX_FIN   = 8'd254;
   localparam logic [7:0] EXP_ONE       = 8'd127;
   localparam logic [7:0] EXP_INT       = 8'd150;
   localparam logic [7:0] LOG_BIAS      = 8'd104;

   typedef enum logic {
      OP_LOG = 1'b0,
      OP_EXP = 1'b1
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] value;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [31:0] result;
      logic        range_flag;
      logic        last_out;
   } rsp_type;

   // position of the highest set bit of a 31-bit word
   function automatic logic [4:0] msb_pos(input logic [30:0] a);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 0; i < 31; i++) begin
         if (a[i]) p = 5'(i);
      end
      return p;
   endfunction

endpackage

[rtl/core/float_pseudo_log2_exp2_converter_top.sv]
// pseudo log2 / exp2 converter for IEEE single-precision words, top level
// depends on fplog_pkg
// path: request beat -> input register -> result register -> response beat
// throughput: one beat per cycle while rsp_ready is not held low, set by the single compute pass between the registers
// reset: synchronous, active high; clears both valid flags, low_exp returns to 127
module float_pseudo_log2_exp2_converter_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  fplog_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fplog_pkg::rsp_type rsp_data
);
   import fplog_pkg::*;

   logic [7:0] low_exp_ff;
   logic       s1_valid_ff, s1_valid_in;
   req_type    s1_data_ff;
   logic       s2_valid_ff, s2_valid_in;
   rsp_type    s2_data_ff, s2_data_in;
   logic       adv2, adv1;

   // handshake
   assign adv2        = !s2_valid_ff || rsp_ready;
   assign adv1        = !s1_valid_ff || adv2;
   assign req_ready   = adv1;
   assign s1_valid_in = adv1 ? req_valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid   = s2_valid_ff;
   assign rsp_data    = s2_data_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_exp_ff  <= LOW_EXP_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) low_exp_ff <= csr_wr_data;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv1) s1_data_ff <= req_data;
      if (adv2) s2_data_ff <= s2_data_in;
   end

   // compute pass
   always_comb begin
      logic        sgn;
      logic [7:0]  e;
      logic [22:0] frac;
      logic        flag;
      logic [31:0] res;
      // log path
      logic [7:0]  el;
      logic [8:0]  d;
      logic [31:0] sum;
      logic        neg;
      logic [30:0] a;
      logic [4:0]  p;
      logic [30:0] nrm;
      logic        up;
      logic [7:0]  biased;
      logic [30:0] mag;
      // exp path
      logic [23:0] s;
      logic [30:0] t;
      logic [22:0] ffrac;
      logic        ovf;
      logic [4:0]  sh;
      logic [47:0] x;
      logic [23:0] q;
      logic        qup;
      logic [31:0] ex;
      logic [46:0] fs;

      sgn  = s1_data_ff.value[31];
      e    = s1_data_ff.value[30:23];
      frac = s1_data_ff.value[22:0];
      flag = 1'b0;
      res  = '0;

      // log: sum = (e - low_exp) * 2^23 + fraction, then normalize with rne
      el  = (e == EXP_ALL_ONES) ? EXP_MAX_FIN : e;
      d   = {1'b0, el} - {1'b0, low_exp_ff};
      sum = {d, frac};
      neg = sum[31];
      a   = neg ? 31'(-sum) : sum[30:0];
      p   = msb_pos(a);
      nrm = a << (5'd30 - p);
      up  = nrm[6] & ((|nrm[5:0]) | nrm[7]);
      biased = 8'(p) + LOG_BIAS;
      mag = {biased, 23'd0} + {8'd0, nrm[29:7]} + {30'd0, up};
      if (a == '0) mag = '0;

      // exp: integer part and rounded fraction of the magnitude
      s     = (e != 8'd0) ? {1'b1, frac} : {1'b0, frac};
      t     = '0;
      ffrac = '0;
      ovf   = 1'b0;
      fs    = {23'd0, s} << 5'(e - EXP_ONE);
      sh    = (e != 8'd0) ? 5'(EXP_ONE - e) : 5'd26;
      if (e < EXP_ONE && (EXP_ONE - e) >= 8'd25) sh = 5'd26;
      x     = {s, 24'd0} >> sh;
      q     = x[47:24];
      qup   = x[23] & ((|x[22:0]) | q[0]);
      if (e >= EXP_INT) begin
         if (e - EXP_INT >= 8'd8) ovf = 1'b1;
         else t = {7'd0, s} << 3'(e - EXP_INT);
      end else if (e >= EXP_ONE) begin
         t     = {7'd0, s >> 5'(EXP_INT - e)};
         ffrac = fs[22:0];
      end else if (sh <= 5'd24) begin
         ffrac = 23'(q + {23'd0, qup});
      end
      ex = {1'b0, t} + {24'd0, low_exp_ff};

      case (s1_data_ff.op)
         OP_LOG: begin
            flag = (e == EXP_ALL_ONES);
            res  = {neg | sgn, mag};
         end
         OP_EXP: begin
            if (e == EXP_ALL_ONES) begin
               flag = 1'b1;
               res  = {sgn, EXP_MAX_FIN, 23'd0};
            end else if (ovf || ex > {24'd0, EXP_MAX_FIN}) begin
               flag = 1'b1;
               res  = {sgn, EXP_MAX_FIN, ffrac};
            end else begin
               res  = {sgn, ex[7:0], ffrac};
            end
         end
         default: begin
            res = '0;
         end
      endcase

      s2_data_in.result     = res;
      s2_data_in.range_flag = flag;
      s2_data_in.last_out   = s1_data_ff.last_in;
   end

endmodule

[tb/tb_top.sv]
// self-checking testbench for the pseudo log2 / exp2 single-float converter
// depends on fplog_pkg and float_pseudo_log2_exp2_converter_top
module tb_top;
   import fplog_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // predictor copy of the register
   logic [7:0] low_exp_q = LOW_EXP_RESET;

   req_type pending_beats[$];
   rsp_type expected_rsps[$];
   int      fail_count = 0;
   int      rx_hold = 0;
   int      tx_gap = 0;
   bit      long_hold_req = 1'b0;

   float_pseudo_log2_exp2_converter_top u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // round-to-nearest-even right shift, sh >= 1
   function automatic logic [63:0] shr_rne(input logic [63:0] x, input int sh);
      logic [63:0] q, rem, half;
      q = x >> sh;
      rem = x & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      return q;
   endfunction

   function automatic rsp_type predict_transform(input req_type r, input logic [7:0] lo);
      rsp_type     o;
      logic        sgn;
      logic [31:0] e;
      logic [22:0] frac;
      longint      k, sum;
      logic [63:0] a, sig, s, t, ex, q;
      logic [31:0] biased, mag, ffrac;
      int          p, n, sh;
      logic        neg, ovf;
      o = '0;
      o.last_out = r.last_in;
      sgn = r.value[31];
      e = {24'd0, r.value[30:23]};
      frac = r.value[22:0];
      if (r.op == OP_LOG) begin
         if (e == 32'hFF) begin
            o.range_flag = 1'b1;
            e = 32'd254;
         end
         k = longint'(e) - longint'(lo) - 1;
         sum = k * 64'sh800000 + longint'({1'b1, frac});
         neg = sum < 0;
         a = neg ? 64'(-sum) : 64'(sum);
         if (a == 0) mag = 0;
         else begin
            p = 0;
            while ((a >> (p + 1)) != 0) p++;
            biased = 32'(p + 104);
            if (p <= 23) sig = a << (23 - p);
            else begin
               sig = shr_rne(a, p - 23);
               if (sig == (64'd1 << 24)) begin
                  sig = sig >> 1;
                  biased++;
               end
            end
            mag = (biased << 23) | (32'(sig) & 32'h7FFFFF);
         end
         o.result = mag | {neg | sgn, 31'd0};
      end else begin
         if (e == 32'hFF) begin
            o.range_flag = 1'b1;
            o.result = {sgn, 8'd254, 23'd0};
         end else begin
            s = (e != 0) ? {40'd0, 1'b1, frac} : {41'd0, frac};
            t = 0;
            ffrac = 0;
            ovf = 1'b0;
            if (e >= 150) begin
               if (e - 150 >= 8) ovf = 1'b1;
               else t = s << (e - 150);
            end else if (e >= 127) begin
               n = 150 - int'(e);
               t = s >> n;
               ffrac = 32'((s & ((64'd1 << n) - 64'd1)) << (23 - n));
            end else begin
               sh = (e != 0) ? 127 - int'(e) : 126;
               q = (sh >= 25) ? 64'd0 : shr_rne(s, sh);
               ffrac = (q >= 64'h800000) ? 32'd0 : 32'(q);
            end
            ex = t + 64'(lo);
            if (ovf || ex > 254) begin
               o.range_flag = 1'b1;
               ex = 254;
            end
            o.result = {sgn, 31'd0} | (32'(ex) << 23) | ffrac;
         end
      end
      return o;
   endfunction

   function automatic req_type make_beat(input op_type op, input logic [31:0] v);
      req_type b;
      b.op = op;
      b.value = v;
      b.last_in = 1'($urandom_range(0, 1));
      return b;
   endfunction

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // random float with exponents clustered near 127
   function automatic logic [31:0] rand_float();
      logic [7:0] ex;
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 3) ex = 8'($urandom_range(0, 255));
      else if (sel < 5) ex = 8'($urandom_range(120, 160));
      else if (sel < 6) ex = 8'(sel == 5 ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 0);
      else ex = 8'($urandom_range(100, 135));
      return {1'($urandom_range(0, 1)), ex, 23'($urandom())};
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // hold the offered beat
      end else if (tx_gap > 0) begin
         tx_gap <= tx_gap - 1;
         req_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
         req_data <= pending_beats[0];
         expected_rsps.push_back(predict_transform(pending_beats[0], low_exp_q));
         void'(pending_beats.pop_front());
         req_valid <= 1'b1;
         tx_gap <= draw_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver stall control
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold_req && rx_hold == 0) begin
         rx_hold <= 300;
         long_hold_req <= 1'b0;
         rsp_ready <= 1'b0;
      end else if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
         rx_hold <= draw_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: compare each accepted beat with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected beat result=%h", rsp_data.result);
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.result !== want.result) begin
               $error("result: expected %h actual %h", want.result, rsp_data.result);
               fail_count++;
            end
            if (rsp_data.range_flag !== want.range_flag) begin
               $error("range_flag: expected %b actual %b", want.range_flag,
                      rsp_data.range_flag);
               fail_count++;
            end
            if (rsp_data.last_out !== want.last_out) begin
               $error("last_out: expected %b actual %b", want.last_out, rsp_data.last_out);
               fail_count++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_beats.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_low_exp(input logic [7:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      low_exp_q = v;
      @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++)
         pending_beats.push_back(make_beat(op_type'($urandom_range(0, 1)), rand_float()));
   endtask

   // stimulus
   initial begin
      logic [7:0] settings[6];
      logic [31:0] corners[12];
      settings = '{8'd127, 8'd0, 8'd255, 8'd1, 8'd254, 8'd100};
      corners = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h007F_FFFF,
                  32'h3F80_0000, 32'h3F00_0000, 32'h7F80_0000, 32'hFFC0_0001,
                  32'h7F7F_FFFF, 32'h4B7F_FFFF, 32'h3F7F_FFFF, 32'h4300_0000};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed corners at reset setting
      foreach (corners[i]) begin
         pending_beats.push_back(make_beat(OP_LOG, corners[i]));
         pending_beats.push_back(make_beat(OP_EXP, corners[i]));
      end
      wait_drained();
      for (int ph = 0; ph < 6; ph++) begin
         write_low_exp(settings[ph]);
         if (ph == 2) long_hold_req = 1'b1;
         queue_random(240);
         wait_drained();
      end
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
